[design/blg_pkg.sv]
`default_nettype none
package blg_pkg;

  localparam int COORD_BITS = 6;
  localparam int ERR_BITS   = COORD_BITS + 3;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef struct packed {
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } in_data_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_data_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request
    logic setup;  // derive walk state from captured request
    logic emit;   // push one pixel and advance
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;  // output register empty or draining this cycle
    logic at_end;     // current pixel is the last of the line
  } dp_sts_t;

endpackage
`default_nettype wire

[design/blg_ctrl.sv]
`default_nettype none
module blg_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire blg_pkg::dp_sts_t sts,
  output blg_pkg::dp_cmd_t      cmd
);
  import blg_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (sts.slot_free && sts.at_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd.load  = 1'b0;
    cmd.setup = 1'b0;
    cmd.emit  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_WALK: begin
        cmd.emit = sts.slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[design/blg_dp.sv]
`default_nettype none
module blg_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire blg_pkg::in_data_t  in_data,
  input  wire blg_pkg::dp_cmd_t   cmd,
  output blg_pkg::dp_sts_t        sts,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output blg_pkg::out_data_t      out_data
);
  import blg_pkg::*;

  in_data_t  req_r;
  coord_t    cur_major_r, cur_minor_r, end_major_r;
  coord_t    delta_major_r, delta_minor_r;
  err_t      err_r;
  logic      step_down_r, x_major_r;
  logic      out_valid_r;
  out_data_t out_data_r;

  // setup terms
  coord_t adx, ady, sa, sb, ea, eb, a0, b0, a1, b1;
  logic   x_major, down;
  coord_t d_major, d_minor;
  err_t   err_init;

  // walk terms
  logic   take_step, at_end;
  err_t   two_dmin, two_dmaj;

  always_comb begin
    adx = (req_r.x_end >= req_r.x_start) ? req_r.x_end - req_r.x_start
                                         : req_r.x_start - req_r.x_end;
    ady = (req_r.y_end >= req_r.y_start) ? req_r.y_end - req_r.y_start
                                         : req_r.y_start - req_r.y_end;
    x_major = adx > ady;  // equal spans go y-major
    a0 = x_major ? req_r.x_start : req_r.y_start;
    b0 = x_major ? req_r.y_start : req_r.x_start;
    a1 = x_major ? req_r.x_end   : req_r.y_end;
    b1 = x_major ? req_r.y_end   : req_r.x_end;
    if (a1 < a0) begin
      sa = a1; sb = b1; ea = a0; eb = b0;
    end else begin
      sa = a0; sb = b0; ea = a1; eb = b1;
    end
    down     = eb < sb;
    d_major  = ea - sa;
    d_minor  = down ? sb - eb : eb - sb;
    err_init = err_t'({2'b00, d_minor, 1'b0}) - err_t'({3'b000, d_major});
  end

  always_comb begin
    two_dmin  = err_t'({2'b00, delta_minor_r, 1'b0});
    two_dmaj  = err_t'({2'b00, delta_major_r, 1'b0});
    // x-major steps on err >= 0, y-major only on err > 0
    take_step = x_major_r ? !err_r[ERR_BITS-1]
                          : (!err_r[ERR_BITS-1] && (err_r != '0));
    at_end    = cur_major_r == end_major_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.setup) begin
      cur_major_r   <= sa;
      cur_minor_r   <= sb;
      end_major_r   <= ea;
      delta_major_r <= d_major;
      delta_minor_r <= d_minor;
      err_r         <= err_init;
      step_down_r   <= down;
      x_major_r     <= x_major;
    end else if (cmd.emit) begin
      out_data_r.pixel_x    <= x_major_r ? cur_major_r : cur_minor_r;
      out_data_r.pixel_y    <= x_major_r ? cur_minor_r : cur_major_r;
      out_data_r.last_pixel <= at_end;
      cur_major_r           <= cur_major_r + 1'b1;
      if (take_step) begin
        cur_minor_r <= step_down_r ? cur_minor_r - 1'b1 : cur_minor_r + 1'b1;
        err_r       <= err_r + two_dmin - two_dmaj;
      end else begin
        err_r       <= err_r + two_dmin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.at_end    = at_end;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule
`default_nettype wire

[design/bresenham_line_generator_core.sv]
`default_nettype none
// Bresenham line generator. Each input transfer carries a line request with
// two endpoints; the block answers with one output transfer per pixel of the
// rasterized line, in order of rising major coordinate, with last_pixel set
// on the final one. Lines whose x span is strictly larger than the y span are
// walked along x, all others along y (equal spans are y-major). A line of
// span D (the larger of |dx| and |dy|) yields D+1 pixels. A request passes
// through an accept state, then a setup state that sorts the endpoints and
// computes the spans, then the walk loop, which gives one pixel per cycle
// while the output is not stalled and whose single error adder updates the
// decision term each pixel. The output has a register of its own, so a new
// request is accepted while the final pixel of the previous line still
// waits to be taken. Backpressure on out_ready simply holds the walk.
module bresenham_line_generator_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire blg_pkg::in_data_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output blg_pkg::out_data_t      out_data
);
  import blg_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle -> setup -> walk
  blg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // request capture, walk registers and output register
  blg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[verif/bresenham_line_generator_core_test.sv]
`default_nettype none
module bresenham_line_generator_core_test;
  import blg_pkg::*;

  localparam int LONG_HOLD   = 400;   // receiver hold-off, in cycles
  localparam int IDLE_LIMIT  = 3000;  // cycles with no transfer before we give up
  localparam int DRAIN_WAIT  = 70;    // one full line plus setup
  localparam int RANDOM_A    = 60;
  localparam int BURST_LINES = 20;
  localparam int RANDOM_B    = 60;

  // Holds the pixels the block still owes, oldest first.
  class pixel_scoreboard;
    out_data_t owed_pixels[$];
    int        failures;
    int        pixels_checked;

    function new();
      failures = 0;
      pixels_checked = 0;
    endfunction

    // Rasterize one accepted line request and queue its pixels.
    function void note_request(in_data_t req);
      int        adx, ady, dmaj, dmin;
      coord_t    sa, sb, ea, eb, t;
      coord_t    cur_maj, cur_min;
      err_t      err;
      bit        xmaj, down, last;
      out_data_t px;
      adx  = (req.x_end >= req.x_start) ? int'(req.x_end) - int'(req.x_start)
                                        : int'(req.x_start) - int'(req.x_end);
      ady  = (req.y_end >= req.y_start) ? int'(req.y_end) - int'(req.y_start)
                                        : int'(req.y_start) - int'(req.y_end);
      xmaj = (adx > ady);  // equal spans walk along y
      if (xmaj) begin
        sa = req.x_start; sb = req.y_start; ea = req.x_end; eb = req.y_end;
      end else begin
        sa = req.y_start; sb = req.x_start; ea = req.y_end; eb = req.x_end;
      end
      if (ea < sa) begin
        t = sa; sa = ea; ea = t;
        t = sb; sb = eb; eb = t;
      end
      down    = (eb < sb);
      dmaj    = int'(ea) - int'(sa);
      dmin    = down ? int'(sb) - int'(eb) : int'(eb) - int'(sb);
      err     = err_t'(2 * dmin - dmaj);
      cur_maj = sa;
      cur_min = sb;
      last    = 0;
      while (!last) begin
        last          = (cur_maj == ea);
        px.pixel_x    = xmaj ? cur_maj : cur_min;
        px.pixel_y    = xmaj ? cur_min : cur_maj;
        px.last_pixel = last;
        owed_pixels.push_back(px);
        // x-major steps on error >= 0, y-major only on error > 0
        if (xmaj ? (err >= 0) : (err > 0)) begin
          cur_min = down ? cur_min - 1'b1 : cur_min + 1'b1;
          err     = err_t'(err + 2 * dmin - 2 * dmaj);
        end else begin
          err = err_t'(err + 2 * dmin);
        end
        if (!last) cur_maj = cur_maj + 1'b1;
      end
    endfunction

    function void check_pixel(out_data_t got);
      out_data_t want;
      if (owed_pixels.size() == 0) begin
        $error("pixel (%0d,%0d) arrived with none owed", got.pixel_x, got.pixel_y);
        failures++;
        return;
      end
      want = owed_pixels.pop_front();
      pixels_checked++;
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x mismatch: expected %0d, actual %0d", want.pixel_x, got.pixel_x);
        failures++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y mismatch: expected %0d, actual %0d", want.pixel_y, got.pixel_y);
        failures++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel mismatch: expected %0d, actual %0d",
               want.last_pixel, got.last_pixel);
        failures++;
      end
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_data_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_data_t out_data;

  pixel_scoreboard sb = new();

  int  lines_sent = 0;
  int  idle_cycles = 0;
  int  holds_done = 0;
  bit  hold_request = 0;

  bresenham_line_generator_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Monitor: both channels sampled at the edge, before any drive updates land.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_request(in_data);
      lines_sent++;
    end
    if (rst_n && out_valid && out_ready) sb.check_pixel(out_data);
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, calm stretches, and one long hold on request.
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left  = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_request) begin
        out_ready <= 1'b0;
        stall_left = LONG_HOLD - 1;
        hold_request = 0;
        holds_done++;
      end else if (calm_left > 0) begin
        out_ready <= 1'b1;
        calm_left--;
      end else begin
        case ($urandom_range(19))
          0:          calm_left = $urandom_range(80, 20);
          1, 2, 3:    begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(2, 0);
          end
          4:          begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(40, 8);
          end
          default:    out_ready <= 1'b1;
        endcase
        if (calm_left > 0) out_ready <= 1'b1;
      end
    end
  end

  function automatic in_data_t line_req(int xs, int ys, int xe, int ye);
    in_data_t r;
    r.x_start = coord_t'(xs);
    r.y_start = coord_t'(ys);
    r.x_end   = coord_t'(xe);
    r.y_end   = coord_t'(ye);
    return r;
  endfunction

  function automatic coord_t near_coord(coord_t c);
    int v;
    v = int'(c) + $urandom_range(8) - 4;
    if (v < 0) v = 0;
    if (v > 63) v = 63;
    return coord_t'(v);
  endfunction

  // Arbitrary endpoints, or short, axis-aligned, diagonal and point lines.
  function automatic in_data_t random_line();
    in_data_t r;
    int       span;
    r = in_data_t'($urandom);
    case ($urandom_range(9))
      0, 1: begin
        r.x_end = near_coord(r.x_start);
        r.y_end = near_coord(r.y_start);
      end
      2:    r.y_end = r.y_start;
      3:    r.x_end = r.x_start;
      4: begin
        span = $urandom_range(63 - r.x_start);
        r.x_end = coord_t'(r.x_start + span);
        r.y_end = (r.y_start >= span) ? coord_t'(r.y_start - span)
                                      : coord_t'(r.y_start + span);
        if (r.y_start < span && r.y_start + span > 63) r.y_end = r.y_start;
      end
      5: begin
        r.x_end = r.x_start;
        r.y_end = r.y_start;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one line; on transfer, optionally leave a gap before the next.
  task automatic send_line(in_data_t req, bit allow_gap);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = 0;
    if (allow_gap) begin
      case ($urandom_range(9))
        0, 1, 2: gap = $urandom_range(3, 1);
        3:       gap = $urandom_range(60, 15);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One edge first, so the monitor has queued the line just transferred.
  task automatic drain_lines();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    in_data_t directed[$];
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(line_req(0, 0, 0, 0));      // single point
    directed.push_back(line_req(63, 63, 63, 63));
    directed.push_back(line_req(0, 0, 63, 0));     // full-width horizontal
    directed.push_back(line_req(63, 5, 0, 5));
    directed.push_back(line_req(7, 0, 7, 63));     // full-height vertical
    directed.push_back(line_req(9, 63, 9, 0));
    directed.push_back(line_req(0, 0, 63, 63));    // equal spans, y-major
    directed.push_back(line_req(63, 0, 0, 63));
    directed.push_back(line_req(0, 0, 2, 1));      // x-major tie on zero error
    directed.push_back(line_req(0, 0, 1, 2));      // y-major tie on zero error
    directed.push_back(line_req(0, 0, 4, 2));
    directed.push_back(line_req(0, 0, 2, 4));
    directed.push_back(line_req(0, 63, 63, 62));
    directed.push_back(line_req(10, 20, 3, 40));
    directed.push_back(line_req(0, 0, 63, 62));    // x span one above y span
    directed.push_back(line_req(0, 0, 62, 63));
    directed.push_back(line_req(42, 21, 21, 42));
    directed.push_back(line_req(1, 2, 3, 3));
    directed.push_back(line_req(63, 0, 0, 31));
    directed.push_back(line_req(21, 42, 42, 21));
    foreach (directed[i]) send_line(directed[i], 1'b1);
    drain_lines();  // sender waits out every owed pixel

    repeat (RANDOM_A) send_line(random_line(), 1'b1);

    // Long receiver hold while requests keep coming back to back.
    hold_request = 1;
    repeat (BURST_LINES) send_line(random_line(), 1'b0);
    drain_lines();

    repeat (RANDOM_B) send_line(random_line(), 1'b1);
    drain_lines();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("tb: %0d line requests, %0d pixels checked, %0d long output holds",
             lines_sent, sb.pixels_checked, holds_done);
    $display("tb: covered points, axis lines, diagonals, tie-breaks and random spans");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire
